### sv/rme_pkg.sv
// ----------------------------------------------------------------------------
// rme_pkg
// Shared types and constants for the register machine execute block.
// ----------------------------------------------------------------------------
package rme_pkg;

	localparam int unsigned WORD_W       = 16;
	localparam int unsigned IDX_W        = 4;
	localparam int unsigned NUM_REGS_DEF = 16;
	localparam int unsigned CNT_W        = 5;

	// Instruction groups.
	localparam logic [3:0] GRP_ALU  = 4'h0;
	localparam logic [3:0] GRP_MOVE = 4'h1;
	localparam logic [3:0] GRP_JUMP = 4'h2;
	localparam logic [3:0] GRP_CLR  = 4'hF;

	// Functions of the ALU group.
	localparam logic [3:0] FN_ADD = 4'h0;
	localparam logic [3:0] FN_SUB = 4'h1;
	localparam logic [3:0] FN_MUL = 4'h2;
	localparam logic [3:0] FN_DIV = 4'h3;
	localparam logic [3:0] FN_AND = 4'h4;
	localparam logic [3:0] FN_OR  = 4'h5;
	localparam logic [3:0] FN_NOT = 4'h6;
	localparam logic [3:0] FN_XOR = 4'h7;
	localparam logic [3:0] FN_SHR = 4'h8;
	localparam logic [3:0] FN_SHL = 4'h9;

	// Functions of the move group (also jump uses FN_LDI code 0).
	localparam logic [3:0] FN_LDI  = 4'h0;
	localparam logic [3:0] FN_COPY = 4'h1;
	localparam logic [3:0] FN_SWAP = 4'h2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	// Start request to the serial unit.
	typedef struct packed {
		logic             start;
		logic [3:0]       fn;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
	} su_req_t;

	// Completion report of the serial unit.
	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] result;
		logic              div_zero;
	} su_rsp_t;

endpackage

### sv/register_machine_execute.sv
// ----------------------------------------------------------------------------
// register_machine_execute
// Executes one instruction per item against a program counter and a
// register file and reports the new pc and every register write.
// ----------------------------------------------------------------------------
// ALU-group instructions (add through shift left) run through a bit-serial
// unit that handles one operand bit per cycle, so they take longer than all
// other instructions. The block takes one item at a time; its result waits
// in an output register until taken while the next item is already accepted
// and executed, and the register file holds NUM_REGS words.
module register_machine_execute #(
	parameter int unsigned NUM_REGS = rme_pkg::NUM_REGS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [rme_pkg::WORD_W-1:0] instr_word,
	input  logic [rme_pkg::WORD_W-1:0] imm_word,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [rme_pkg::WORD_W-1:0] next_pc,
	output logic                       dest_valid,
	output logic [rme_pkg::IDX_W-1:0]  dest_index,
	output logic [rme_pkg::WORD_W-1:0] dest_value,
	output logic                       swap_valid,
	output logic [rme_pkg::IDX_W-1:0]  swap_index,
	output logic [rme_pkg::WORD_W-1:0] swap_value,
	output logic                       regs_cleared,
	output logic                       div_zero
);
	import rme_pkg::*;

	state_t            state_q;
	state_t            state_nxt;
	logic [WORD_W-1:0] pc_q;
	logic [WORD_W-1:0] regs_q [NUM_REGS];
	logic [WORD_W-1:0] ins_q;
	logic [WORD_W-1:0] imm_q;
	logic [3:0]        grp;
	logic [3:0]        fn;
	logic [IDX_W-1:0]  rx;
	logic [IDX_W-1:0]  ry;
	logic              rx_ok;
	logic              ry_ok;
	logic [WORD_W-1:0] a_val;
	logic [WORD_W-1:0] b_val;
	logic              is_alu;
	logic              go;
	logic              finish;
	logic              out_free;
	su_req_t           su_req;
	su_rsp_t           su_rsp;

	logic              o_valid_q;
	logic [WORD_W-1:0] o_pc_q;
	logic              o_dv_q;
	logic [IDX_W-1:0]  o_di_q;
	logic [WORD_W-1:0] o_dval_q;
	logic              o_sv_q;
	logic [IDX_W-1:0]  o_si_q;
	logic [WORD_W-1:0] o_sval_q;
	logic              o_clr_q;
	logic              o_dz_q;

	// Instruction fields of the held item.
	assign grp   = ins_q[15:12];
	assign fn    = ins_q[11:8];
	assign rx    = ins_q[7:4];
	assign ry    = ins_q[3:0];
	assign rx_ok = (32'(rx) < NUM_REGS);
	assign ry_ok = (32'(ry) < NUM_REGS);
	assign a_val = rx_ok ? regs_q[rx[$clog2(NUM_REGS)-1:0]] : '0;
	assign b_val = ry_ok ? regs_q[ry[$clog2(NUM_REGS)-1:0]] : '0;
	assign is_alu = (grp == GRP_ALU) && (fn <= FN_SHL);

	assign go       = in_valid && !in_stall;
	assign finish   = is_alu ? su_rsp.done : 1'b1;
	assign out_free = !o_valid_q || !out_stall;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: if (go) state_nxt = ST_RUN;
			ST_RUN:  if (finish) state_nxt = ST_DONE;
			ST_DONE: if (out_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs of the controller.
	always_comb begin
		in_stall      = (state_q != ST_IDLE);
		su_req.start  = (state_q == ST_IDLE) && go;
		su_req.fn     = instr_word[11:8];
		su_req.a      = '0;
		su_req.b      = '0;
		if (32'(instr_word[7:4]) < NUM_REGS) begin
			su_req.a = regs_q[instr_word[4 +: $clog2(NUM_REGS)]];
		end
		if (32'(instr_word[3:0]) < NUM_REGS) begin
			su_req.b = regs_q[instr_word[0 +: $clog2(NUM_REGS)]];
		end
		if (!((instr_word[15:12] == GRP_ALU) && (instr_word[11:8] <= FN_SHL))) begin
			su_req.start = 1'b0;
		end
	end

	rme_serial_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (su_req),
		.rsp    (su_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			ins_q <= instr_word;
			imm_q <= imm_word;
		end
	end

	// Architectural state and result register; the result is written once the
	// output register is free, which may be in the cycle its old item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= '0;
			o_valid_q <= 1'b0;
			o_pc_q    <= '0;
			o_dv_q    <= 1'b0;
			o_di_q    <= '0;
			o_dval_q  <= '0;
			o_sv_q    <= 1'b0;
			o_si_q    <= '0;
			o_sval_q  <= '0;
			o_clr_q   <= 1'b0;
			o_dz_q    <= 1'b0;
			for (int i = 0; i < int'(NUM_REGS); i++) begin
				regs_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_DONE && out_free) begin
				o_valid_q <= 1'b1;
				o_dv_q    <= 1'b0;
				o_di_q    <= '0;
				o_dval_q  <= '0;
				o_sv_q    <= 1'b0;
				o_si_q    <= '0;
				o_sval_q  <= '0;
				o_clr_q   <= 1'b0;
				o_dz_q    <= 1'b0;
				o_pc_q    <= pc_q;
				case (grp)
					GRP_ALU: begin
						pc_q   <= pc_q + WORD_W'(2);
						o_pc_q <= pc_q + WORD_W'(2);
						if (is_alu) begin
							o_dz_q <= su_rsp.div_zero;
							if (rx_ok) begin
								regs_q[rx[$clog2(NUM_REGS)-1:0]] <= su_rsp.result;
								o_dv_q   <= 1'b1;
								o_di_q   <= rx;
								o_dval_q <= su_rsp.result;
							end
						end
					end
					GRP_MOVE: begin
						pc_q   <= pc_q + ((fn == FN_LDI) ? WORD_W'(4) : WORD_W'(2));
						o_pc_q <= pc_q + ((fn == FN_LDI) ? WORD_W'(4) : WORD_W'(2));
						if (fn == FN_LDI || fn == FN_COPY || fn == FN_SWAP) begin
							if (rx_ok) begin
								regs_q[rx[$clog2(NUM_REGS)-1:0]] <=
									(fn == FN_LDI) ? imm_q : b_val;
								o_dv_q   <= 1'b1;
								o_di_q   <= rx;
								o_dval_q <= (fn == FN_LDI) ? imm_q :
									((fn == FN_SWAP && rx == ry) ? a_val : b_val);
							end
						end
						if (fn == FN_SWAP && ry_ok) begin
							if (rx != ry) begin
								regs_q[ry[$clog2(NUM_REGS)-1:0]] <= a_val;
							end
							o_sv_q   <= 1'b1;
							o_si_q   <= ry;
							o_sval_q <= a_val;
						end
					end
					GRP_JUMP: begin
						if (fn == FN_LDI) begin
							pc_q   <= imm_q;
							o_pc_q <= imm_q;
						end
					end
					GRP_CLR: begin
						pc_q    <= '0;
						o_pc_q  <= '0;
						o_clr_q <= 1'b1;
						for (int i = 0; i < int'(NUM_REGS); i++) begin
							regs_q[i] <= '0;
						end
					end
					default: begin
						o_pc_q <= pc_q;
					end
				endcase
			end else if (o_valid_q && !out_stall) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = o_valid_q;
	assign next_pc      = o_pc_q;
	assign dest_valid   = o_dv_q;
	assign dest_index   = o_di_q;
	assign dest_value   = o_dval_q;
	assign swap_valid   = o_sv_q;
	assign swap_index   = o_si_q;
	assign swap_value   = o_sval_q;
	assign regs_cleared = o_clr_q;
	assign div_zero     = o_dz_q;

endmodule

### sv/rme_serial_alu.sv
// ----------------------------------------------------------------------------
// rme_serial_alu
// Bit-serial ALU: one bit of the operands per cycle.
// ----------------------------------------------------------------------------
module rme_serial_alu (
	input  logic             clk,
	input  logic             arst_n,
	input  rme_pkg::su_req_t req,
	output rme_pkg::su_rsp_t rsp
);
	import rme_pkg::*;

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [3:0]        fn_q;
	logic [WORD_W-1:0] a_q;
	logic [WORD_W-1:0] b_q;
	logic [WORD_W-1:0] acc_q;
	logic [WORD_W-1:0] rem_q;
	logic              carry_q;
	logic              dz_q;
	logic              done_q;
	logic              last;
	logic              sum_bit;
	logic              sum_carry;
	logic              bbit;
	logic [WORD_W:0]   rem_sh;
	logic [WORD_W:0]   rem_sub;
	logic [WORD_W-1:0] sh_amt_src;
	logic              wide_shift;

	assign last = (cnt_q == CNT_W'(WORD_W - 1));

	// Serial add or subtract of the low bits; b is inverted for subtract.
	assign bbit      = (fn_q == FN_SUB) ? ~b_q[0] : b_q[0];
	assign sum_bit   = a_q[0] ^ bbit ^ carry_q;
	assign sum_carry = (a_q[0] & bbit) | (a_q[0] & carry_q) | (bbit & carry_q);

	// Restoring division step: one quotient bit from the top of a.
	assign rem_sh  = {rem_q, a_q[WORD_W-1]};
	assign rem_sub = rem_sh - {1'b0, b_q};

	// The original shift amount is held in rem_q for shift ops.
	assign sh_amt_src = rem_q;
	assign wide_shift = (sh_amt_src[WORD_W-1:4] != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: each op consumes one bit per cycle.
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			fn_q    <= req.fn;
			a_q     <= req.a;
			b_q     <= req.b;
			acc_q   <= '0;
			carry_q <= (req.fn == FN_SUB);
			dz_q    <= (req.fn == FN_DIV) && (req.b == '0);
			rem_q   <= ((req.fn == FN_SHR) || (req.fn == FN_SHL)) ? req.b : '0;
			if (req.fn == FN_SHL) begin
				acc_q <= req.a;
			end
			if (req.fn == FN_SHR) begin
				acc_q <= req.a;
			end
		end else if (busy_q) begin
			case (fn_q)
				FN_ADD, FN_SUB: begin
					acc_q   <= {sum_bit, acc_q[WORD_W-1:1]};
					carry_q <= sum_carry;
					a_q     <= a_q >> 1;
					b_q     <= b_q >> 1;
				end
				FN_MUL: begin
					// Shift-and-add from the multiplier's low bit.
					if (b_q[0]) begin
						acc_q <= acc_q + a_q;
					end
					a_q <= a_q << 1;
					b_q <= b_q >> 1;
				end
				FN_DIV: begin
					if (!rem_sub[WORD_W]) begin
						rem_q <= rem_sub[WORD_W-1:0];
						acc_q <= {acc_q[WORD_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh[WORD_W-1:0];
						acc_q <= {acc_q[WORD_W-2:0], 1'b0};
					end
					a_q <= a_q << 1;
				end
				FN_AND, FN_OR, FN_XOR, FN_NOT: begin
					case (fn_q)
						FN_AND:  acc_q <= {a_q[0] & b_q[0], acc_q[WORD_W-1:1]};
						FN_OR:   acc_q <= {a_q[0] | b_q[0], acc_q[WORD_W-1:1]};
						FN_XOR:  acc_q <= {a_q[0] ^ b_q[0], acc_q[WORD_W-1:1]};
						default: acc_q <= {~a_q[0], acc_q[WORD_W-1:1]};
					endcase
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
				end
				FN_SHR, FN_SHL: begin
					// Shift one place per cycle while the count remains.
					if (wide_shift) begin
						acc_q <= '0;
					end else if (cnt_q < {1'b0, sh_amt_src[3:0]}) begin
						acc_q <= (fn_q == FN_SHR) ? (acc_q >> 1) : (acc_q << 1);
					end
				end
				default: begin
					acc_q <= '0;
				end
			endcase
		end
	end

	always_comb begin
		rsp.done     = done_q;
		rsp.result   = dz_q ? {WORD_W{1'b1}} : acc_q;
		rsp.div_zero = dz_q;
	end

endmodule

### verif/tb_register_machine_execute.sv
// ----------------------------------------------------------------------------
// tb_register_machine_execute
// Self-checking bench for the register machine execute block. Instructions
// are driven from a queue, a shadow register file and pc predict each result,
// and every output item is compared field by field against the oldest
// prediction while both sides idle and stall at random in several phases.
// ----------------------------------------------------------------------------
module tb_register_machine_execute;
	import rme_pkg::*;

	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [15:0] instr;
		logic [15:0] imm;
	} instr_item_t;

	typedef struct packed {
		logic [15:0] pc;
		logic        dv;
		logic [3:0]  di;
		logic [15:0] dval;
		logic        sv;
		logic [3:0]  si;
		logic [15:0] sval;
		logic        clr;
		logic        dz;
	} exec_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] instr_word = '0;
	logic [15:0] imm_word = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] next_pc;
	logic        dest_valid;
	logic [3:0]  dest_index;
	logic [15:0] dest_value;
	logic        swap_valid;
	logic [3:0]  swap_index;
	logic [15:0] swap_value;
	logic        regs_cleared;
	logic        div_zero;

	instr_item_t  pending_instrs[$];
	exec_result_t expected_results[$];
	logic [15:0]  shadow_regs[16];
	logic [15:0]  shadow_pc;
	int           send_idle_pct = 0;
	int           stall_pct = 0;
	int           error_count = 0;
	int           result_count = 0;
	int           quiet_cycles = 0;

	register_machine_execute u_top (.*);

	always #4 clk = ~clk;

	// Compute the expected result of one instruction and update the shadow state.
	function automatic exec_result_t execute_instr(instr_item_t it);
		exec_result_t r;
		logic [3:0]   grp, fn, rx, ry;
		logic [15:0]  a, b, v;
		logic         wr;
		r = '0;
		grp = it.instr[15:12];
		fn = it.instr[11:8];
		rx = it.instr[7:4];
		ry = it.instr[3:0];
		a = shadow_regs[rx];
		b = shadow_regs[ry];
		v = '0;
		wr = 1'b0;
		r.pc = shadow_pc;
		case (grp)
			GRP_ALU: begin
				wr = 1'b1;
				case (fn)
					FN_ADD: v = a + b;
					FN_SUB: v = a - b;
					FN_MUL: v = a * b;
					FN_DIV: begin
						if (b == 0) begin
							v = 16'hFFFF;
							r.dz = 1'b1;
						end else begin
							v = a / b;
						end
					end
					FN_AND: v = a & b;
					FN_OR:  v = a | b;
					FN_NOT: v = ~a;
					FN_XOR: v = a ^ b;
					FN_SHR: v = (b >= 16) ? 16'h0 : a >> b;
					FN_SHL: v = (b >= 16) ? 16'h0 : a << b;
					default: wr = 1'b0;
				endcase
				r.pc = shadow_pc + 16'd2;
			end
			GRP_MOVE: begin
				r.pc = shadow_pc + 16'd2;
				if (fn == FN_LDI) begin
					wr = 1'b1;
					v = it.imm;
					r.pc = shadow_pc + 16'd4;
				end else if (fn == FN_COPY) begin
					wr = 1'b1;
					v = b;
				end else if (fn == FN_SWAP) begin
					// Swapping a register with itself reports it twice, unchanged.
					wr = 1'b1;
					v = b;
					r.sv = 1'b1;
					r.si = ry;
					r.sval = a;
					shadow_regs[ry] = a;
				end
			end
			GRP_JUMP: begin
				if (fn == FN_LDI)
					r.pc = it.imm;
			end
			GRP_CLR: begin
				foreach (shadow_regs[i])
					shadow_regs[i] = '0;
				r.pc = '0;
				r.clr = 1'b1;
			end
			default: ;
		endcase
		if (wr) begin
			shadow_regs[rx] = v;
			r.dv = 1'b1;
			r.di = rx;
			r.dval = v;
		end
		shadow_pc = r.pc;
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch on result %0d: %s got %h, expected %h", result_count, what, got, want);
		error_count++;
	endtask

	// Driver: hold each instruction until accepted, idle at random between items.
	always @(posedge clk) begin
		instr_item_t it;
		if (arst_n) begin
			if (!(in_valid && in_stall)) begin
				if (in_valid)
					expected_results.push_back(
						execute_instr(instr_item_t'{instr_word, imm_word}));
				if (pending_instrs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					it = pending_instrs.pop_front();
					in_valid <= 1'b1;
					instr_word <= it.instr;
					imm_word <= it.imm;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Monitor: compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		exec_result_t want;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("unexpected result with next_pc %h", next_pc);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (next_pc !== want.pc) report_mismatch("next_pc", next_pc, want.pc);
					if (dest_valid !== want.dv)
						report_mismatch("dest_valid", dest_valid, want.dv);
					if (dest_index !== want.di)
						report_mismatch("dest_index", dest_index, want.di);
					if (dest_value !== want.dval)
						report_mismatch("dest_value", dest_value, want.dval);
					if (swap_valid !== want.sv)
						report_mismatch("swap_valid", swap_valid, want.sv);
					if (swap_index !== want.si)
						report_mismatch("swap_index", swap_index, want.si);
					if (swap_value !== want.sval)
						report_mismatch("swap_value", swap_value, want.sval);
					if (regs_cleared !== want.clr)
						report_mismatch("regs_cleared", regs_cleared, want.clr);
					if (div_zero !== want.dz) report_mismatch("div_zero", div_zero, want.dz);
				end
				result_count <= result_count + 1;
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_register_machine_execute: done, errors");
			$finish;
		end
	end

	function automatic instr_item_t make_instr(logic [3:0] g, logic [3:0] f, logic [3:0] x,
			logic [3:0] y, logic [15:0] imm);
		return instr_item_t'{{g, f, x, y}, imm};
	endfunction

	// Random instruction, mostly from the defined opcodes.
	function automatic instr_item_t random_instr();
		logic [3:0]  g, f;
		logic [15:0] w;
		int          pick;
		w = 16'($urandom);
		pick = $urandom_range(99);
		if (pick < 55) begin
			g = GRP_ALU;
			f = 4'($urandom_range(9));
		end else if (pick < 80) begin
			g = GRP_MOVE;
			f = 4'($urandom_range(2));
		end else if (pick < 86) begin
			g = GRP_JUMP;
			f = FN_LDI;
		end else if (pick < 88) begin
			g = GRP_CLR;
			f = 4'($urandom);
		end else begin
			g = 4'($urandom);
			f = 4'($urandom);
		end
		return make_instr(g, f, w[7:4], w[3:0], 16'($urandom));
	endfunction

	task automatic run_phase(int idle, int stall, int count);
		send_idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < count; i++) begin
			// Load small values often so shifts, divides and wide shifts all occur.
			if ($urandom_range(3) == 0)
				pending_instrs.push_back(make_instr(GRP_MOVE, FN_LDI, 4'($urandom), 4'h0,
					$urandom_range(1) ? 16'($urandom_range(20)) : 16'($urandom)));
			else
				pending_instrs.push_back(random_instr());
		end
		wait (pending_instrs.size() == 0 && !in_valid);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		// Directed: extremes, every operation and each special case.
		pending_instrs.push_back(make_instr(GRP_MOVE, FN_LDI, 4'h0, 4'h0, 16'hFFFF));
		pending_instrs.push_back(make_instr(GRP_MOVE, FN_LDI, 4'hF, 4'h0, 16'h0011));
		pending_instrs.push_back(make_instr(GRP_MOVE, FN_LDI, 4'h1, 4'h0, 16'h0003));
		pending_instrs.push_back(make_instr(GRP_ALU, FN_ADD, 4'h0, 4'hF, 16'h0));
		pending_instrs.push_back(make_instr(GRP_ALU, FN_SUB, 4'h1, 4'hF, 16'h0));
		pending_instrs.push_back(make_instr(GRP_ALU, FN_MUL, 4'h0, 4'h0, 16'h0));
		pending_instrs.push_back(make_instr(GRP_ALU, FN_DIV, 4'hF, 4'h1, 16'h0));
		pending_instrs.push_back(make_instr(GRP_ALU, FN_DIV, 4'h1, 4'h5, 16'h0));
		pending_instrs.push_back(make_instr(GRP_ALU, FN_AND, 4'h0, 4'h1, 16'h0));
		pending_instrs.push_back(make_instr(GRP_ALU, FN_OR, 4'h0, 4'hF, 16'h0));
		pending_instrs.push_back(make_instr(GRP_ALU, FN_NOT, 4'h2, 4'h0, 16'h0));
		pending_instrs.push_back(make_instr(GRP_ALU, FN_XOR, 4'h2, 4'h0, 16'h0));
		pending_instrs.push_back(make_instr(GRP_ALU, FN_SHR, 4'h2, 4'hF, 16'h0));
		pending_instrs.push_back(make_instr(GRP_ALU, FN_SHL, 4'h0, 4'h1, 16'h0));
		pending_instrs.push_back(make_instr(GRP_ALU, 4'hA, 4'h0, 4'h1, 16'h0));
		pending_instrs.push_back(make_instr(GRP_MOVE, FN_COPY, 4'h3, 4'h0, 16'h0));
		pending_instrs.push_back(make_instr(GRP_MOVE, FN_SWAP, 4'h3, 4'hF, 16'h0));
		pending_instrs.push_back(make_instr(GRP_MOVE, FN_SWAP, 4'h3, 4'h3, 16'h0));
		pending_instrs.push_back(make_instr(GRP_MOVE, 4'hF, 4'h0, 4'h0, 16'h0));
		pending_instrs.push_back(make_instr(GRP_JUMP, FN_LDI, 4'h0, 4'h0, 16'hFFFE));
		pending_instrs.push_back(make_instr(GRP_ALU, FN_ADD, 4'h0, 4'h0, 16'h0));
		pending_instrs.push_back(make_instr(GRP_JUMP, 4'h7, 4'h0, 4'h0, 16'h1234));
		pending_instrs.push_back(make_instr(4'h5, 4'h3, 4'h2, 4'h1, 16'hFFFF));
		pending_instrs.push_back(make_instr(4'hE, 4'hF, 4'hF, 4'hF, 16'h0));
		pending_instrs.push_back(make_instr(GRP_CLR, 4'h0, 4'h0, 4'h0, 16'h0));
		run_phase(0, 0, 0);
		run_phase(0, 0, 320);
		run_phase(68, 0, 320);
		run_phase(0, 68, 320);
		run_phase(36, 36, 320);
		wait (expected_results.size() == 0);
		repeat (40) @(posedge clk);
		$display("Ran %0d results over directed ops and four idle/stall phases.", result_count);
		if (error_count == 0)
			$display("tb_register_machine_execute: done, clean");
		else
			$display("tb_register_machine_execute: done, errors");
		$finish;
	end

	initial begin
		shadow_pc = '0;
		foreach (shadow_regs[i])
			shadow_regs[i] = '0;
	end

endmodule
